// ===== hdl/dbba_pkg.sv =====
// ----------------------------------------------------------------------------
// dbba_pkg
// shared widths, codes and types of the block bitmap allocator
// ----------------------------------------------------------------------------
package dbba_pkg;

    localparam int DEF_MAX_BLOCKS = 256;   // default capacity, 2 to 256
    localparam int WORD_BITS      = 16;    // map bits held by one cell
    localparam int WORD_IDX_W     = 4;     // bit select inside a cell word
    localparam int CELL_IDX_W     = 4;     // cell select from a block number
    localparam int BLK_W          = 8;
    localparam int CNT_W          = 9;
    localparam int SEC_W          = 14;
    localparam int STAT_W         = 3;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;
    localparam int PROD_W         = 16;

    localparam logic [SEC_W-1:0] SECTOR_MAX = 14'd16383;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MAP    = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTALLOC = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNDER    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_TRACK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_BLOCK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_COUNT     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_FORMAT,
        S_MAP,
        S_MULT
    } t_state;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             fmt;     // clear the word
        logic             keep0;   // on format, reserve block 0
        logic             clr;     // clear the addressed bit
        logic [BLK_W-1:0] blk;     // addressed block
        logic [CNT_W-1:0] eff;     // effective block count
    } t_cell_cmd;

    // report of one cell back to the control
    typedef struct packed {
        logic                  hit;      // claimed a free bit this cycle
        logic [WORD_IDX_W-1:0] bit_idx;  // which bit was claimed
        logic                  sel;      // addressed bit lives here and is set
        logic                  tok;      // search token handed to next cell
    } t_cell_stat;

endpackage

// ===== hdl/dbba_cell.sv =====
// ----------------------------------------------------------------------------
// dbba_cell
// one sixteen-bit word of the allocation map with its search step
// ----------------------------------------------------------------------------
module dbba_cell
    import dbba_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_active,   // search token arrives this cycle
    input  t_cell_cmd  i_cmd,
    output t_cell_stat o_stat
);

    localparam logic [CNT_W-1:0] BASE = CNT_W'(IDX * WORD_BITS);

    logic [WORD_BITS-1:0]  r_word;
    logic [WORD_BITS-1:0]  n_word;
    logic                  r_tok;
    logic                  n_tok;
    logic [WORD_BITS-1:0]  free_mask;
    logic [WORD_IDX_W-1:0] first_free;
    logic                  hit;
    logic                  addr_here;

    // free bits that lie below the effective block count
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            free_mask[j] = !r_word[j] && ((BASE + CNT_W'(j)) < i_cmd.eff);
        end
    end

    // lowest free bit
    always_comb begin
        first_free = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_mask[j]) begin
                first_free = WORD_IDX_W'(j);
            end
        end
    end

    assign hit       = i_active && (|free_mask);
    assign addr_here = (i_cmd.blk[BLK_W-1 -: CELL_IDX_W] == CELL_IDX_W'(IDX));

    always_comb begin
        n_word = r_word;
        if (i_cmd.fmt) begin
            n_word = '0;
            if (IDX == 0 && i_cmd.keep0) begin
                n_word[0] = 1'b1;
            end
        end else if (i_cmd.clr && addr_here) begin
            n_word[i_cmd.blk[WORD_IDX_W-1:0]] = 1'b0;
        end else if (hit) begin
            n_word[first_free] = 1'b1;
        end
    end

    assign n_tok = i_active && !hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_tok  <= 1'b0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_stat.hit     = hit;
    assign o_stat.bit_idx = first_free;
    assign o_stat.sel     = addr_here && r_word[i_cmd.blk[WORD_IDX_W-1:0]];
    assign o_stat.tok     = r_tok;

endmodule

// ===== hdl/disk_block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// disk_block_bitmap_allocator
// one-bit-per-block allocation map with first-fit allocate, free, format
// and block-to-sector mapping
// ----------------------------------------------------------------------------
// usage
//   command channel: a transfer happens on a clock edge with start high and
//   busy low; i_mode and i_block_in are sampled on that edge
//   result channel: o_done is high for exactly one cycle with the result on
//   o_block_out, o_sector_out, o_status and o_used_blocks; the receiver
//   cannot hold it off, so results are never stalled or dropped
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx;
//   the user writes only while busy is low, the block does not enforce it
// steps from the command edge to the cycle o_done is high
//   allocate: the search ends in the cell that holds the block (16 blocks
//             a cell), or past the last cell when the disk is full;
//             the search token steps one cell per cycle along the chain
//   free, format: the S_FREE or S_FORMAT state, then the registered result
//   map: S_MAP (track and multiply), then S_MULT (saturation)
// one command at a time; busy stays high until the result cycle
// the next command is taken at the edge that ends the result cycle at the
//   earliest, so a new command is never taken before the last result
// reset: map cleared, used count zero, configuration registers to their defaults
// ----------------------------------------------------------------------------
module disk_block_bitmap_allocator
    import dbba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [BLK_W-1:0]      i_block_in,
    // result channel
    output logic                  o_done,
    output logic [BLK_W-1:0]      o_block_out,
    output logic [SEC_W-1:0]      o_sector_out,
    output logic [STAT_W-1:0]     o_status,
    output logic [CNT_W-1:0]      o_used_blocks,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int N_CELLS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BLOCKS);

    // configuration registers
    logic [7:0]       r_dir_track;
    logic [6:0]       r_block_sectors;
    logic [CNT_W-1:0] r_middle_block;
    logic [CNT_W-1:0] r_blk_count;

    // control
    t_state           r_state;
    t_state           n_state;
    logic             r_launch;
    logic             n_launch;
    logic [BLK_W-1:0] r_blk;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // map datapath
    logic [PROD_W-1:0] r_prod;
    logic              r_under;
    logic [CNT_W-1:0]  track;
    logic [CNT_W-1:0]  down;
    logic              under;

    // result registers
    logic              r_done;
    logic              n_done;
    logic [BLK_W-1:0]  r_block_out;
    logic [BLK_W-1:0]  n_block_out;
    logic [SEC_W-1:0]  r_sector_out;
    logic [SEC_W-1:0]  n_sector_out;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    // cell chain
    t_cell_cmd             cmd;
    t_cell_stat            stat [N_CELLS];
    logic [N_CELLS-1:0]    cell_active;
    logic [CNT_W-1:0]      eff;
    logic                  in_range;
    logic                  any_hit;
    logic                  any_sel;
    logic [BLK_W-1:0]      found_blk;
    logic                  end_tok;

    // effective block count, limited to capacity
    assign eff      = (r_blk_count > CAP) ? CAP : r_blk_count;
    assign in_range = (CNT_W'(r_blk) < eff);
    assign busy     = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_track     <= 8'd0;
            r_block_sectors <= 7'd1;
            r_middle_block  <= 9'd128;
            r_blk_count     <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIR_TRACK:     r_dir_track     <= i_cfg_data[7:0];
                CFG_BLOCK_SECTORS: r_block_sectors <= i_cfg_data[6:0];
                CFG_MIDDLE_BLOCK:  r_middle_block  <= i_cfg_data;
                CFG_BLK_COUNT:     r_blk_count     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // broadcast to the cells
    assign cmd.fmt   = (r_state == S_FORMAT);
    assign cmd.keep0 = (eff != '0);
    assign cmd.clr   = (r_state == S_FREE) && in_range;
    assign cmd.blk   = r_blk;
    assign cmd.eff   = eff;

    // the token enters at cell 0 and walks one cell per cycle
    genvar k;
    generate
        for (k = 0; k < N_CELLS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign cell_active[k] = r_launch;
            end else begin : g_link
                assign cell_active[k] = stat[k-1].tok;
            end
            dbba_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_active (cell_active[k]),
                .i_cmd    (cmd),
                .o_stat   (stat[k])
            );
        end
    endgenerate

    // gather the cell reports; at most one cell holds the token
    always_comb begin
        any_hit   = 1'b0;
        any_sel   = 1'b0;
        found_blk = '0;
        for (int c = 0; c < N_CELLS; c++) begin
            any_sel = any_sel | stat[c].sel;
            if (stat[c].hit) begin
                any_hit   = 1'b1;
                found_blk = {CELL_IDX_W'(c), stat[c].bit_idx};
            end
        end
    end

    // token fell off the end of the chain: no free block
    assign end_tok = stat[N_CELLS-1].tok;

    // track of the mapped block, counting outward then back below
    always_comb begin
        down  = 9'd1 + CNT_W'(r_blk) - r_middle_block;
        under = 1'b0;
        if (CNT_W'(r_blk) < r_middle_block) begin
            track = CNT_W'(r_dir_track) + CNT_W'(r_blk);
        end else if (down > CNT_W'(r_dir_track)) begin
            under = 1'b1;
            track = '0;
        end else begin
            track = CNT_W'(r_dir_track) - down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP) begin
            r_prod  <= PROD_W'(track) * PROD_W'(r_block_sectors);
            r_under <= under;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        MODE_ALLOC:  n_state = S_SCAN;
                        MODE_FREE:   n_state = S_FREE;
                        MODE_FORMAT: n_state = S_FORMAT;
                        MODE_MAP:    n_state = S_MAP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (any_hit || end_tok) begin
                    n_state = S_IDLE;
                end
            end
            S_MAP:    n_state = S_MULT;
            S_FREE:   n_state = S_IDLE;
            S_FORMAT: n_state = S_IDLE;
            S_MULT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and count
    always_comb begin
        n_launch     = (r_state == S_IDLE) && start && (i_mode == MODE_ALLOC);
        n_done       = 1'b0;
        n_count      = r_count;
        n_block_out  = r_block_out;
        n_sector_out = r_sector_out;
        n_status     = r_status;
        case (r_state)
            S_SCAN: begin
                if (any_hit) begin
                    n_done       = 1'b1;
                    n_block_out  = found_blk;
                    n_sector_out = '0;
                    n_status     = STAT_OK;
                    n_count      = r_count + 9'd1;
                end else if (end_tok) begin
                    n_done       = 1'b1;
                    n_block_out  = '0;
                    n_sector_out = '0;
                    n_status     = STAT_FULL;
                end
            end
            S_FREE: begin
                n_done       = 1'b1;
                n_block_out  = r_blk;
                n_sector_out = '0;
                if (!in_range) begin
                    n_status = STAT_RANGE;
                end else if (!any_sel) begin
                    n_status = STAT_NOTALLOC;
                end else begin
                    n_status = STAT_OK;
                    n_count  = r_count - 9'd1;
                end
            end
            S_FORMAT: begin
                n_done       = 1'b1;
                n_block_out  = '0;
                n_sector_out = '0;
                n_status     = STAT_OK;
                n_count      = (eff != '0) ? 9'd1 : 9'd0;
            end
            S_MULT: begin
                n_done      = 1'b1;
                n_block_out = r_blk;
                if (r_under) begin
                    n_status     = STAT_UNDER;
                    n_sector_out = '0;
                end else begin
                    n_status     = STAT_OK;
                    // saturate at the top logical sector
                    n_sector_out = (r_prod > PROD_W'(SECTOR_MAX)) ? SECTOR_MAX
                                                                  : r_prod[SEC_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_done   <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_done   <= n_done;
            r_count  <= n_count;
        end
    end

    // command capture and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_blk  <= i_block_in;
        end
        r_block_out  <= n_block_out;
        r_sector_out <= n_sector_out;
        r_status     <= n_status;
    end

    // count seen on the result is the count after the operation
    assign o_done        = r_done;
    assign o_block_out   = r_block_out;
    assign o_sector_out  = r_sector_out;
    assign o_status      = r_status;
    assign o_used_blocks = r_count;

endmodule

// ===== hdl/dbba_checker.sv =====
// ----------------------------------------------------------------------------
// dbba_checker
// port-level checks of the block bitmap allocator
// ----------------------------------------------------------------------------
module dbba_checker
    import dbba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [BLK_W-1:0]  o_block_out,
    input logic [SEC_W-1:0]  o_sector_out,
    input logic [STAT_W-1:0] o_status,
    input logic [CNT_W-1:0]  o_used_blocks
);

    // an accepted command always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // a result strobe never stays high beyond its result cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // a full disk returns block zero and no sector
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STAT_FULL |-> o_block_out == '0 && o_sector_out == '0)
        else $error("disk full result carries a block or sector");

    // track underflow returns no sector
    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STAT_UNDER |-> o_sector_out == '0)
        else $error("track underflow result carries a sector");

    // the used count on a result never exceeds 256, the largest map size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_used_blocks <= 9'd256)
        else $error("used count beyond map size");

endmodule

bind disk_block_bitmap_allocator dbba_checker u_dbba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_block_out   (o_block_out),
    .o_sector_out  (o_sector_out),
    .o_status      (o_status),
    .o_used_blocks (o_used_blocks)
);
